// ----- hw/rtl/rbi_pkg.sv -----
package rbi_pkg;

    localparam int COORD_W = 32;
    localparam int FRAC_W  = 16;
    localparam int EPS_W   = 17;
    localparam int IDX_W   = 3;

    localparam int BOX_W  = COORD_W + 4;
    localparam int NUM_W  = COORD_W + 5;
    localparam int DEN_W  = COORD_W + 1;
    localparam int QUO_W  = COORD_W - 1;
    localparam int REM_W  = COORD_W + 2;
    localparam int DIV_SH = QUO_W - FRAC_W;
    localparam int DIV_LAT = QUO_W + 1;
    localparam int PROD_W = QUO_W + COORD_W;
    localparam int PS_W   = PROD_W - FRAC_W;
    localparam int P_W    = COORD_W + 3;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    localparam logic signed [COORD_W-1:0] T_MAX = {1'b0, {(COORD_W-1){1'b1}}};
    localparam logic signed [COORD_W-1:0] T_MIN = {1'b1, {(COORD_W-1){1'b0}}};
    localparam logic signed [COORD_W-1:0] T_WITHIN = -(2 ** FRAC_W);
    localparam logic signed [COORD_W-1:0] BOX_LO_RST = -(2 ** (FRAC_W - 1));
    localparam logic signed [COORD_W-1:0] BOX_HI_RST = 2 ** (FRAC_W - 1);
    localparam logic [EPS_W-1:0] EPS_RST = 1;
    localparam logic [P_W-1:0] PROD_CAP = {1'b1, {(P_W-1){1'b0}}};

    typedef enum logic [IDX_W-1:0] {
        CFG_MIN_X = 3'd0,
        CFG_MIN_Y = 3'd1,
        CFG_MIN_Z = 3'd2,
        CFG_MAX_X = 3'd3,
        CFG_MAX_Y = 3'd4,
        CFG_MAX_Z = 3'd5,
        CFG_EPS   = 3'd6
    } t_cfg_idx;

    typedef enum logic [1:0] {
        CLS_WITHIN = 2'd0,
        CLS_BELOW  = 2'd1,
        CLS_ABOVE  = 2'd2
    } t_cls;

    typedef enum logic [1:0] {
        AXIS_X = 2'd0,
        AXIS_Y = 2'd1,
        AXIS_Z = 2'd2
    } t_axis;

    typedef struct packed {
        logic signed [BOX_W-1:0] c2;
        logic signed [BOX_W-1:0] bmin2;
        logic signed [BOX_W-1:0] bmax2;
    } t_box_axis;

    typedef struct packed {
        t_box_axis [2:0]  ax;
        logic [EPS_W-1:0] eps;
    } t_box;

    typedef struct packed {
        logic signed [COORD_W-1:0] o;
        logic                      d_neg;
        logic                      d_zero;
        logic [COORD_W-1:0]        ad;
        logic [NUM_W-1:0]          an;
        logic                      num_neg;
        t_cls                      cls;
        logic                      big;
    } t_task_axis;

    typedef struct packed {
        t_task_axis [2:0] ax;
        logic             in_box;
        t_axis            in_axis;
    } t_task;

    typedef struct packed {
        logic                      hit;
        logic                      from_inside;
        logic signed [COORD_W-1:0] distance;
        logic signed [COORD_W-1:0] point_x;
        logic signed [COORD_W-1:0] point_y;
        logic signed [COORD_W-1:0] point_z;
        t_axis                     normal_axis;
        logic                      normal_negative;
    } t_hit;

    function automatic logic signed [COORD_W-1:0] clamp_coord(
        input logic signed [BOX_W-1:0] v);
        logic signed [COORD_W-1:0] r;
        if (v > BOX_W'(T_MAX)) begin
            r = T_MAX;
        end else if (v < BOX_W'(T_MIN)) begin
            r = T_MIN;
        end else begin
            r = v[COORD_W-1:0];
        end
        return r;
    endfunction

endpackage

// ----- hw/rtl/rbi_ray_if.sv -----
interface rbi_ray_if import rbi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic signed [COORD_W-1:0] origin_x;
    logic signed [COORD_W-1:0] origin_y;
    logic signed [COORD_W-1:0] origin_z;
    logic signed [COORD_W-1:0] dir_x;
    logic signed [COORD_W-1:0] dir_y;
    logic signed [COORD_W-1:0] dir_z;

    modport source (output valid, output origin_x, output origin_y, output origin_z,
                    output dir_x, output dir_y, output dir_z, input ready);
    modport sink (input valid, input origin_x, input origin_y, input origin_z,
                  input dir_x, input dir_y, input dir_z, output ready);
endinterface

// ----- hw/rtl/rbi_hit_if.sv -----
interface rbi_hit_if import rbi_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic                      hit;
    logic                      from_inside;
    logic signed [COORD_W-1:0] distance;
    logic signed [COORD_W-1:0] point_x;
    logic signed [COORD_W-1:0] point_y;
    logic signed [COORD_W-1:0] point_z;
    logic [1:0]                normal_axis;
    logic                      normal_negative;

    modport source (output valid, output hit, output from_inside, output distance,
                    output point_x, output point_y, output point_z, output normal_axis,
                    output normal_negative, input ready);
    modport sink (input valid, input hit, input from_inside, input distance,
                  input point_x, input point_y, input point_z, input normal_axis,
                  input normal_negative, output ready);
endinterface

// ----- hw/rtl/rbi_front.sv -----
module rbi_front import rbi_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rbi_ray_if.sink   i_ray,
    input  t_box      i_box,
    output logic      o_task_valid,
    input  logic      i_task_ready,
    output t_task     o_task
);

    logic                      r_valid;
    logic signed [COORD_W-1:0] r_o [3];
    logic signed [COORD_W-1:0] r_d [3];

    logic signed [BOX_W-1:0]   o2 [3];
    logic signed [BOX_W-1:0]   cand2 [3];
    logic signed [NUM_W-1:0]   num [3];
    logic [BOX_W:0]            m [3];
    logic signed [BOX_W:0]     md [3];
    logic                      in_box;

    assign i_ray.ready  = !r_valid || i_task_ready;
    assign o_task_valid = r_valid;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ray.ready) begin
            r_valid <= i_ray.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ray.valid && i_ray.ready) begin
            r_o[0] <= i_ray.origin_x;
            r_o[1] <= i_ray.origin_y;
            r_o[2] <= i_ray.origin_z;
            r_d[0] <= i_ray.dir_x;
            r_d[1] <= i_ray.dir_y;
            r_d[2] <= i_ray.dir_z;
        end
    end

    always_comb begin
        in_box = 1'b1;
        for (int i = 0; i < 3; i++) begin
            o2[i] = BOX_W'(r_o[i]) <<< 1;
            o_task.ax[i].o      = r_o[i];
            o_task.ax[i].d_neg  = r_d[i][COORD_W-1];
            o_task.ax[i].d_zero = (r_d[i] == '0);
            o_task.ax[i].ad     = r_d[i][COORD_W-1] ? COORD_W'(-r_d[i]) : r_d[i];
            o_task.ax[i].big    = o_task.ax[i].ad > COORD_W'(i_box.eps);
            if (o2[i] < i_box.ax[i].bmin2) begin
                o_task.ax[i].cls = CLS_BELOW;
                cand2[i] = i_box.ax[i].bmin2;
                in_box = 1'b0;
            end else if (o2[i] > i_box.ax[i].bmax2) begin
                o_task.ax[i].cls = CLS_ABOVE;
                cand2[i] = i_box.ax[i].bmax2;
                in_box = 1'b0;
            end else begin
                o_task.ax[i].cls = CLS_WITHIN;
                cand2[i] = '0;
            end
            num[i] = NUM_W'(cand2[i]) - NUM_W'(o2[i]);
            o_task.ax[i].num_neg = num[i][NUM_W-1];
            o_task.ax[i].an = num[i][NUM_W-1] ? NUM_W'(-num[i]) : NUM_W'(num[i]);
            md[i] = (BOX_W+1)'(o2[i]) - (BOX_W+1)'(i_box.ax[i].c2);
            m[i]  = md[i][BOX_W] ? (BOX_W+1)'(-md[i]) : (BOX_W+1)'(md[i]);
        end
        o_task.in_box = in_box;
        if (m[0] > m[1] && m[0] > m[2]) begin
            o_task.in_axis = AXIS_X;
        end else if (m[1] > m[0] && m[1] > m[2]) begin
            o_task.in_axis = AXIS_Y;
        end else begin
            o_task.in_axis = AXIS_Z;
        end
    end

endmodule

// ----- hw/rtl/rbi_fifo.sv -----
module rbi_fifo import rbi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_push,
    input  t_task i_data,
    output logic  o_not_full,
    input  logic  i_pop,
    output logic  o_not_empty,
    output t_task o_data
);

    t_task              r_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] r_wr;
    logic [FIFO_AW-1:0] r_rd;
    logic [FIFO_AW:0]   r_count;
    logic               push;
    logic               pop;

    assign o_not_full  = (r_count != (FIFO_AW+1)'(FIFO_DEPTH));
    assign o_not_empty = (r_count != '0);
    assign push        = i_push && o_not_full;
    assign pop         = i_pop && o_not_empty;
    assign o_data      = r_mem[r_rd];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (push) begin
                r_wr <= r_wr + 1'b1;
            end
            if (pop) begin
                r_rd <= r_rd + 1'b1;
            end
            if (push && !pop) begin
                r_count <= r_count + 1'b1;
            end else if (pop && !push) begin
                r_count <= r_count - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

// ----- hw/rtl/rbi_div.sv -----
module rbi_div import rbi_pkg::*; (
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [NUM_W-1:0] i_num,
    input  logic [DEN_W-1:0] i_den,
    output logic [QUO_W-1:0] o_quo,
    output logic             o_sat
);

    logic [REM_W-1:0] r_rem  [QUO_W+1];
    logic [QUO_W-1:0] r_q    [QUO_W+1];
    logic [QUO_W-1:0] r_bits [QUO_W+1];
    logic [DEN_W-1:0] r_den  [QUO_W+1];
    logic             r_sat  [QUO_W+1];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_rem[0]  <= REM_W'(i_num >> DIV_SH);
            r_q[0]    <= '0;
            r_bits[0] <= {i_num[DIV_SH-1:0], {FRAC_W{1'b0}}};
            r_den[0]  <= i_den;
            r_sat[0]  <= (i_num >> DIV_SH) >= NUM_W'(i_den);
        end
    end

    for (genvar k = 1; k <= QUO_W; k++) begin : g_step
        logic [REM_W-1:0] trial;
        logic             ge;

        always_comb begin
            trial = {r_rem[k-1][REM_W-2:0], r_bits[k-1][QUO_W-1]};
            ge    = trial >= REM_W'(r_den[k-1]);
        end

        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rem[k]  <= ge ? trial - REM_W'(r_den[k-1]) : trial;
                r_q[k]    <= {r_q[k-1][QUO_W-2:0], ge};
                r_bits[k] <= r_bits[k-1] << 1;
                r_den[k]  <= r_den[k-1];
                r_sat[k]  <= r_sat[k-1];
            end
        end
    end

    assign o_quo = r_q[QUO_W];
    assign o_sat = r_sat[QUO_W];

endmodule

// ----- hw/rtl/rbi_back.sv -----
module rbi_back import rbi_pkg::*; (
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_task_valid,
    output logic  o_task_ready,
    input  t_task i_task,
    input  t_box  i_box,
    output logic  o_valid,
    input  logic  i_ready,
    output t_hit  o_res
);

    logic                      en;
    logic                      r_sv   [DIV_LAT];
    t_task                     r_side [DIV_LAT];
    logic [QUO_W-1:0]          quo [3];
    logic                      sat [3];

    logic                      r_a_v;
    t_task                     r_a_task;
    logic signed [COORD_W-1:0] r_a_t [3];

    logic                      r_b_v;
    t_task                     r_b_task;
    logic signed [COORD_W-1:0] r_b_tch;
    t_axis                     r_b_ch;

    logic                      r_c_v;
    t_task                     r_c_task;
    logic signed [COORD_W-1:0] r_c_tch;
    t_axis                     r_c_ch;
    logic [PROD_W-1:0]         r_c_prod [3];

    logic                      r_d_v;
    t_task                     r_d_task;
    logic signed [COORD_W-1:0] r_d_tch;
    t_axis                     r_d_ch;
    logic signed [BOX_W-1:0]   r_d_c [3];

    logic                      r_out_valid;
    t_hit                      r_out;

    logic signed [COORD_W-1:0] n_t [3];
    logic signed [COORD_W-1:0] mag [3];
    t_axis                     n_ch;
    logic signed [COORD_W-1:0] n_tch;
    logic [PS_W-1:0]           ps [3];
    logic [P_W-1:0]            p [3];
    logic signed [BOX_W-1:0]   n_c [3];
    logic signed [BOX_W:0]     c2x [3];
    logic signed [BOX_W-1:0]   cand2;
    logic signed [COORD_W-1:0] pt [3];
    logic                      miss;
    t_hit                      n_out;

    assign en           = !r_out_valid || i_ready;
    assign o_task_ready = en;
    assign o_valid      = r_out_valid;
    assign o_res        = r_out;

    for (genvar i = 0; i < 3; i++) begin : g_div
        rbi_div u_div (
            .i_clk (i_clk),
            .i_en  (en),
            .i_num (i_task.ax[i].an),
            .i_den ({i_task.ax[i].ad, 1'b0}),
            .o_quo (quo[i]),
            .o_sat (sat[i])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DIV_LAT; k++) begin
                r_sv[k] <= 1'b0;
            end
            r_a_v       <= 1'b0;
            r_b_v       <= 1'b0;
            r_c_v       <= 1'b0;
            r_d_v       <= 1'b0;
            r_out_valid <= 1'b0;
        end else if (en) begin
            r_sv[0] <= i_task_valid;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_sv[k] <= r_sv[k-1];
            end
            r_a_v       <= r_sv[DIV_LAT-1];
            r_b_v       <= r_a_v;
            r_c_v       <= r_b_v;
            r_d_v       <= r_c_v;
            r_out_valid <= r_d_v;
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            mag[i] = sat[i] ? T_MAX : {1'b0, quo[i]};
            if (r_side[DIV_LAT-1].ax[i].cls == CLS_WITHIN) begin
                n_t[i] = T_WITHIN;
            end else if (r_side[DIV_LAT-1].ax[i].big) begin
                n_t[i] = (r_side[DIV_LAT-1].ax[i].num_neg != r_side[DIV_LAT-1].ax[i].d_neg)
                       ? -mag[i] : mag[i];
            end else if (r_side[DIV_LAT-1].ax[i].d_zero) begin
                n_t[i] = '0;
            end else if (r_side[DIV_LAT-1].ax[i].d_neg) begin
                n_t[i] = -T_MAX;
            end else begin
                n_t[i] = T_MAX;
            end
        end
    end

    always_comb begin
        n_ch  = AXIS_X;
        n_tch = r_a_t[0];
        if (n_tch < r_a_t[1]) begin
            n_ch  = AXIS_Y;
            n_tch = r_a_t[1];
        end
        if (n_tch < r_a_t[2]) begin
            n_ch  = AXIS_Z;
            n_tch = r_a_t[2];
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            ps[i] = r_c_prod[i][PROD_W-1:FRAC_W];
            p[i]  = (ps[i] > PS_W'(PROD_CAP)) ? PROD_CAP : ps[i][P_W-1:0];
            n_c[i] = BOX_W'(r_c_task.ax[i].o)
                   + (r_c_task.ax[i].d_neg ? -$signed(BOX_W'(p[i])) : $signed(BOX_W'(p[i])));
        end
    end

    always_comb begin
        miss  = r_d_tch[COORD_W-1];
        cand2 = (r_d_task.ax[r_d_ch].cls == CLS_BELOW) ? i_box.ax[r_d_ch].bmin2
                                                      : i_box.ax[r_d_ch].bmax2;
        for (int i = 0; i < 3; i++) begin
            c2x[i] = $signed({r_d_c[i], 1'b0});
            if (i == int'(r_d_ch)) begin
                pt[i] = clamp_coord(cand2 >>> 1);
            end else begin
                pt[i] = clamp_coord(r_d_c[i]);
                if (c2x[i] < (BOX_W+1)'(i_box.ax[i].bmin2)
                    || c2x[i] > (BOX_W+1)'(i_box.ax[i].bmax2)) begin
                    miss = 1'b1;
                end
            end
        end
        n_out = '0;
        if (r_d_task.in_box) begin
            n_out.hit         = 1'b1;
            n_out.from_inside = 1'b1;
            n_out.distance    = COORD_W'(i_box.eps);
            n_out.point_x     = r_d_task.ax[0].o;
            n_out.point_y     = r_d_task.ax[1].o;
            n_out.point_z     = r_d_task.ax[2].o;
            n_out.normal_axis = r_d_task.in_axis;
        end else if (!miss) begin
            n_out.hit             = 1'b1;
            n_out.distance        = r_d_tch;
            n_out.point_x         = pt[0];
            n_out.point_y         = pt[1];
            n_out.point_z         = pt[2];
            n_out.normal_axis     = r_d_ch;
            n_out.normal_negative = (r_d_task.ax[r_d_ch].cls == CLS_BELOW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_side[0] <= i_task;
            for (int k = 1; k < DIV_LAT; k++) begin
                r_side[k] <= r_side[k-1];
            end
            r_a_task <= r_side[DIV_LAT-1];
            for (int i = 0; i < 3; i++) begin
                r_a_t[i] <= n_t[i];
            end
            r_b_task <= r_a_task;
            r_b_tch  <= n_tch;
            r_b_ch   <= n_ch;
            r_c_task <= r_b_task;
            r_c_tch  <= r_b_tch;
            r_c_ch   <= r_b_ch;
            for (int i = 0; i < 3; i++) begin
                r_c_prod[i] <= r_b_tch[QUO_W-1:0] * r_b_task.ax[i].ad;
            end
            r_d_task <= r_c_task;
            r_d_tch  <= r_c_tch;
            r_d_ch   <= r_c_ch;
            for (int i = 0; i < 3; i++) begin
                r_d_c[i] <= n_c[i];
            end
            r_out <= n_out;
        end
    end

`ifndef SYNTH
    a_inside_is_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.from_inside |-> r_out.hit)
        else $error("inside result without hit");

    a_miss_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && !r_out.hit |-> r_out.distance == '0 && r_out.point_x == '0
            && r_out.point_y == '0 && r_out.point_z == '0 && !r_out.normal_negative)
        else $error("miss result carries nonzero fields");

    a_entry_nonneg: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_out.hit && !r_out.from_inside |-> !r_out.distance[COORD_W-1])
        else $error("entry hit with negative distance");
`endif

endmodule

// ----- hw/rtl/ray_box_intersection_top.sv -----
// Channel   Dir  Handshake      Word
// i_ray     in   valid/ready    origin_x/y/z, dir_x/y/z (Q16.16)
// o_hit     out  valid/ready    hit, from_inside, distance, point_x/y/z, normal
// i_cfg_*   in   write enable   box corners and epsilon by register index
// One ray is accepted per cycle while the queue has room. The divider has an input stage
// and 31 restoring stages, one quotient bit each.
// Reset is synchronous and active low; it empties the queue and all stages.
// A stall at the output freezes the back pipeline while the front keeps filling the queue.
module ray_box_intersection_top import rbi_pkg::*; (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [IDX_W-1:0]    i_cfg_idx,
    input  logic [COORD_W-1:0]  i_cfg_data,
    rbi_ray_if.sink             i_ray,
    rbi_hit_if.source           o_hit
);

    logic signed [COORD_W-1:0] r_lo [3];
    logic signed [COORD_W-1:0] r_hi [3];
    logic [EPS_W-1:0]          r_eps;

    logic signed [BOX_W-1:0]   w [3];
    logic signed [BOX_W-1:0]   we [3];
    t_box                      box;

    logic                      f_valid;
    logic                      f_ready;
    t_task                     f_task;
    logic                      q_valid;
    logic                      q_pop;
    t_task                     q_task;
    t_hit                      res;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < 3; i++) begin
                r_lo[i] <= BOX_LO_RST;
                r_hi[i] <= BOX_HI_RST;
            end
            r_eps <= EPS_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_MIN_X: r_lo[0] <= i_cfg_data;
                CFG_MIN_Y: r_lo[1] <= i_cfg_data;
                CFG_MIN_Z: r_lo[2] <= i_cfg_data;
                CFG_MAX_X: r_hi[0] <= i_cfg_data;
                CFG_MAX_Y: r_hi[1] <= i_cfg_data;
                CFG_MAX_Z: r_hi[2] <= i_cfg_data;
                CFG_EPS:   r_eps   <= i_cfg_data[EPS_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // A strictly largest width turns the box into a cube about the same center.
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w[i]  = BOX_W'(r_hi[i]) - BOX_W'(r_lo[i]);
            we[i] = w[i];
        end
        if (w[0] > w[1] && w[0] > w[2]) begin
            we[1] = w[0];
            we[2] = w[0];
        end else if (w[1] > w[0] && w[1] > w[2]) begin
            we[0] = w[1];
            we[2] = w[1];
        end else if (w[2] > w[0] && w[2] > w[1]) begin
            we[0] = w[2];
            we[1] = w[2];
        end
        for (int i = 0; i < 3; i++) begin
            box.ax[i].c2    = BOX_W'(r_lo[i]) + BOX_W'(r_hi[i]);
            box.ax[i].bmin2 = box.ax[i].c2 - we[i];
            box.ax[i].bmax2 = box.ax[i].c2 + we[i];
        end
        box.eps = r_eps;
    end

    rbi_front u_front (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_ray        (i_ray),
        .i_box        (box),
        .o_task_valid (f_valid),
        .i_task_ready (f_ready),
        .o_task       (f_task)
    );

    rbi_fifo u_fifo (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (f_valid),
        .i_data      (f_task),
        .o_not_full  (f_ready),
        .i_pop       (q_pop),
        .o_not_empty (q_valid),
        .o_data      (q_task)
    );

    rbi_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_task_valid (q_valid),
        .o_task_ready (q_pop),
        .i_task       (q_task),
        .i_box        (box),
        .o_valid      (o_hit.valid),
        .i_ready      (o_hit.ready),
        .o_res        (res)
    );

    assign o_hit.hit             = res.hit;
    assign o_hit.from_inside     = res.from_inside;
    assign o_hit.distance        = res.distance;
    assign o_hit.point_x         = res.point_x;
    assign o_hit.point_y         = res.point_y;
    assign o_hit.point_z         = res.point_z;
    assign o_hit.normal_axis     = res.normal_axis;
    assign o_hit.normal_negative = res.normal_negative;

endmodule
